FILE: design/audio_compressor_envelope_fsm_unit_macros.svh
// assertion macros for the compressor envelope block
`ifndef AUDIO_COMPRESSOR_ENVELOPE_FSM_UNIT_MACROS_SVH
`define AUDIO_COMPRESSOR_ENVELOPE_FSM_UNIT_MACROS_SVH

// property checked on every rising edge outside reset
`define ACEF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("acef assertion failed");

// condition that must hold in the cycle after a trigger
`define ACEF_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("acef assertion failed");

`endif

FILE: design/acef_pkg.sv
// shared types and constants of the compressor envelope block
package acef_pkg;

  localparam int unsigned RATIO_W  = 16;
  localparam int unsigned LEN_W    = 20;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned RAMP_W   = 25;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [RAMP_W-1:0] ONE_Q24 = 25'h100_0000;

  localparam logic [CFG_IDX_W-1:0] CfgThreshold    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CfgInverseRatio = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CfgAttackLength = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CfgKneeLength   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CfgReleaseLength = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CfgKneeStep     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CfgReleaseStep  = 3'd6;

  localparam logic [RATIO_W-1:0] RstInverseRatio  = 16'd10923;
  localparam logic [LEN_W-1:0]   RstAttackLength  = 20'd2205;
  localparam logic [LEN_W-1:0]   RstKneeLength    = 20'd22050;
  localparam logic [LEN_W-1:0]   RstReleaseLength = 20'd8820;
  localparam logic [STEP_W-1:0]  RstKneeStep      = 24'd761;
  localparam logic [STEP_W-1:0]  RstReleaseStep   = 24'd1902;
  localparam int                 RstThreshold     = 800;

  typedef enum logic [MODE_W-1:0] {
    ModeBypass  = 3'd0,
    ModeAttack  = 3'd1,
    ModeKnee    = 3'd2,
    ModeActive  = 3'd3,
    ModeRelease = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CtrlIdle,
    CtrlBase,
    CtrlRed,
    CtrlDone
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MulRamp,
    MulBase,
    MulRed
  } mul_sel_e;

  typedef enum logic [1:0] {
    RampKnee,
    RampRelease,
    RampFull
  } ramp_kind_e;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     load_ramp;
    logic     load_out;
  } cmd_t;

endpackage

FILE: design/acef_ctrl.sv
// sequencing controller: handshakes and multiplier schedule
module acef_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output acef_pkg::cmd_t cmd_o
);

  acef_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acef_pkg::CtrlIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      acef_pkg::CtrlIdle: begin
        if (in_valid_i) state_d = acef_pkg::CtrlBase;
      end
      acef_pkg::CtrlBase: state_d = acef_pkg::CtrlRed;
      acef_pkg::CtrlRed:  state_d = acef_pkg::CtrlDone;
      acef_pkg::CtrlDone: begin
        if (out_free) state_d = acef_pkg::CtrlIdle;
      end
      default: state_d = acef_pkg::CtrlIdle;
    endcase
  end

  always_comb begin
    cmd_o.capture   = 1'b0;
    cmd_o.mul_en    = 1'b0;
    cmd_o.mul_sel   = acef_pkg::MulRamp;
    cmd_o.load_ramp = 1'b0;
    cmd_o.load_out  = 1'b0;
    in_stall_o      = 1'b1;
    case (state_q)
      acef_pkg::CtrlIdle: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        cmd_o.mul_en  = in_valid_i;
      end
      acef_pkg::CtrlBase: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = acef_pkg::MulBase;
        cmd_o.load_ramp = 1'b1;
      end
      acef_pkg::CtrlRed: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = acef_pkg::MulRed;
      end
      acef_pkg::CtrlDone: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/acef_datapath.sv
// envelope state, configuration registers and shared multiplier datapath
module acef_datapath #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 21,
  parameter int unsigned CFG_W       = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [acef_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]                  cfg_wdata_i,
  input  acef_pkg::cmd_t                    cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_i,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_i,
  output logic signed [SAMPLE_BITS-1:0]     out_left_o,
  output logic signed [SAMPLE_BITS-1:0]     out_right_o,
  output logic [acef_pkg::MODE_W-1:0]       mode_now_o
);

  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned MA_W   = (COUNT_BITS > DIFF_W) ? COUNT_BITS : DIFF_W;
  localparam int unsigned PROD_W = MA_W + acef_pkg::RAMP_W;
  localparam int unsigned CMP_W  = (COUNT_BITS > acef_pkg::LEN_W) ? COUNT_BITS
                                                                  : acef_pkg::LEN_W;

  // configuration
  logic [SAMPLE_BITS-1:0]          thr_q;
  logic [acef_pkg::RATIO_W-1:0]    inv_q;
  logic [acef_pkg::LEN_W-1:0]      atk_len_q, knee_len_q, rel_len_q;
  logic [acef_pkg::STEP_W-1:0]     knee_step_q, rel_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= SAMPLE_BITS'(acef_pkg::RstThreshold);
      inv_q       <= acef_pkg::RstInverseRatio;
      atk_len_q   <= acef_pkg::RstAttackLength;
      knee_len_q  <= acef_pkg::RstKneeLength;
      rel_len_q   <= acef_pkg::RstReleaseLength;
      knee_step_q <= acef_pkg::RstKneeStep;
      rel_step_q  <= acef_pkg::RstReleaseStep;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        acef_pkg::CfgThreshold:     thr_q       <= cfg_wdata_i[SAMPLE_BITS-1:0];
        acef_pkg::CfgInverseRatio:  inv_q       <= cfg_wdata_i[acef_pkg::RATIO_W-1:0];
        acef_pkg::CfgAttackLength:  atk_len_q   <= cfg_wdata_i[acef_pkg::LEN_W-1:0];
        acef_pkg::CfgKneeLength:    knee_len_q  <= cfg_wdata_i[acef_pkg::LEN_W-1:0];
        acef_pkg::CfgReleaseLength: rel_len_q   <= cfg_wdata_i[acef_pkg::LEN_W-1:0];
        acef_pkg::CfgKneeStep:      knee_step_q <= cfg_wdata_i[acef_pkg::STEP_W-1:0];
        acef_pkg::CfgReleaseStep:   rel_step_q  <= cfg_wdata_i[acef_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // envelope mode and phase counter
  acef_pkg::mode_e           mode_q, mode_d;
  logic [COUNT_BITS-1:0]     count_q, count_d, count_base;
  logic                      above, below;
  logic                      apply_d, apply_q;
  acef_pkg::ramp_kind_e      ramp_kind_d, ramp_kind_q;

  assign above = $signed(in_left_i) > $signed(thr_q);
  assign below = $signed(in_left_i) < $signed(thr_q);

  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      acef_pkg::ModeAttack: begin
        if (CMP_W'(count_q) > CMP_W'(atk_len_q)) mode_d = acef_pkg::ModeKnee;
      end
      acef_pkg::ModeKnee: begin
        if (CMP_W'(count_q) > CMP_W'(knee_len_q)) mode_d = acef_pkg::ModeActive;
      end
      acef_pkg::ModeActive: begin
        if (below) mode_d = acef_pkg::ModeRelease;
      end
      acef_pkg::ModeRelease: begin
        if (CMP_W'(count_q) > CMP_W'(rel_len_q)) mode_d = acef_pkg::ModeBypass;
      end
      default: begin
        mode_d = above ? acef_pkg::ModeAttack : acef_pkg::ModeBypass;
      end
    endcase
  end

  always_comb begin
    apply_d     = 1'b0;
    ramp_kind_d = acef_pkg::RampFull;
    case (mode_q)
      acef_pkg::ModeKnee: begin
        apply_d     = above;
        ramp_kind_d = acef_pkg::RampKnee;
      end
      acef_pkg::ModeActive: begin
        apply_d = !below;
      end
      acef_pkg::ModeRelease: begin
        apply_d     = above;
        ramp_kind_d = acef_pkg::RampRelease;
      end
      default: begin
        apply_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_base = (mode_d != mode_q) ? '0 : count_q;
    count_d    = (&count_base) ? count_base : count_base + COUNT_BITS'(1);
  end

  // captured transaction
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic [DIFF_W-1:0]             diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= acef_pkg::ModeBypass;
      count_q <= '0;
    end else if (cmd_i.capture) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      left_q      <= in_left_i;
      right_q     <= in_right_i;
      diff_q      <= {in_left_i[SAMPLE_BITS-1], in_left_i} - {thr_q[SAMPLE_BITS-1], thr_q};
      apply_q     <= apply_d;
      ramp_kind_q <= ramp_kind_d;
    end
  end

  // shared multiplier
  logic [MA_W-1:0]             mul_a;
  logic [acef_pkg::RAMP_W-1:0] mul_b;
  logic [PROD_W-1:0]           prod_q;
  logic [acef_pkg::RAMP_W-1:0] ramp_sat, ramp_d, ramp_q;

  always_comb begin
    case (cmd_i.mul_sel)
      acef_pkg::MulBase: begin
        mul_a = MA_W'(diff_q);
        mul_b = acef_pkg::RAMP_W'(inv_q);
      end
      acef_pkg::MulRed: begin
        mul_a = MA_W'(prod_q[acef_pkg::RATIO_W +: DIFF_W]);
        mul_b = ramp_q;
      end
      default: begin
        mul_a = MA_W'(count_q);
        mul_b = (mode_q == acef_pkg::ModeKnee) ? acef_pkg::RAMP_W'(knee_step_q)
                                               : acef_pkg::RAMP_W'(rel_step_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  always_comb begin
    ramp_sat = (prod_q > PROD_W'(acef_pkg::ONE_Q24)) ? acef_pkg::ONE_Q24
                                                     : prod_q[acef_pkg::RAMP_W-1:0];
    case (ramp_kind_q)
      acef_pkg::RampKnee:    ramp_d = ramp_sat;
      acef_pkg::RampRelease: ramp_d = acef_pkg::ONE_Q24 - ramp_sat;
      default:               ramp_d = acef_pkg::ONE_Q24;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ramp) begin
      ramp_q <= ramp_d;
    end
  end

  // output register
  logic [DIFF_W-1:0]             red;
  logic signed [SAMPLE_BITS-1:0] comp_left;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;
  logic [acef_pkg::MODE_W-1:0]   mode_now_q;

  assign red       = prod_q[acef_pkg::STEP_W +: DIFF_W];
  assign comp_left = left_q - red[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_left_q  <= apply_q ? comp_left : left_q;
      out_right_q <= apply_q ? comp_left : right_q;
      mode_now_q  <= mode_q;
    end
  end

  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;
  assign mode_now_o  = mode_now_q;

endmodule

FILE: design/audio_compressor_envelope_fsm_unit.sv
// top level of the compressor envelope block
//
// one stereo sample pair per input transaction (in_valid_i / in_stall_o),
// one processed pair plus the envelope mode per output transaction
// (out_valid_o / out_stall_i). detection uses the left sample only.
// a transaction passes from acceptance through the base, reduction and
// done states to the result register: one multiplier is shared by the
// ramp, base and reduction products, one product per cycle, and the next
// sample is taken only once the result has been loaded. the result sits
// in an output register; a new sample is accepted while it waits, and the
// block holds before loading the next result until the receiver drops
// out_stall_i. configuration registers are written through cfg_we_i /
// cfg_index_i / cfg_wdata_i; the user must write them only while the
// block is idle, which the block itself does not enforce. unknown indexes
// are ignored. reset puts the envelope in bypass with a cleared phase
// counter and loads the default threshold, ratio, window lengths and steps.
module audio_compressor_envelope_fsm_unit #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 21
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acef_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [((SAMPLE_BITS > acef_pkg::STEP_W) ? SAMPLE_BITS
                                                  : acef_pkg::STEP_W)-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]   in_left_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_right_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]   out_left_o,
  output logic signed [SAMPLE_BITS-1:0]   out_right_o,
  output logic [acef_pkg::MODE_W-1:0]     mode_now_o
);

  localparam int unsigned CFG_W = (SAMPLE_BITS > acef_pkg::STEP_W) ? SAMPLE_BITS
                                                                   : acef_pkg::STEP_W;

  acef_pkg::cmd_t cmd;

  acef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  acef_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .CFG_W       (CFG_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .in_left_i   (in_left_i),
    .in_right_i  (in_right_i),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o),
    .mode_now_o  (mode_now_o)
  );

endmodule

FILE: design/acef_checker.sv
// port level checks of the compressor envelope block, bound to the top level
`include "audio_compressor_envelope_fsm_unit_macros.svh"

module acef_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [SAMPLE_BITS-1:0]        out_left_o,
  input logic [SAMPLE_BITS-1:0]        out_right_o,
  input logic [acef_pkg::MODE_W-1:0]   mode_now_o
);

  // busy for the whole multiply schedule after a transaction
  `ACEF_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |-> ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o)

  // a fresh result only comes out of a running transaction
  `ACEF_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))

  // stalled result holds
  `ACEF_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_left_o) && $stable(out_right_o) && $stable(mode_now_o))

endmodule

bind audio_compressor_envelope_fsm_unit acef_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_acef_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_left_o  (out_left_o),
  .out_right_o (out_right_o),
  .mode_now_o  (mode_now_o)
);

FILE: tb/compressor_checker.sv
`timescale 1ns / 100ps
// predicts and checks the processed sample pairs of the compressor envelope block
module compressor_checker
  import acef_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 21,
  parameter int unsigned WDATA_W     = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [WDATA_W-1:0]            cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [SAMPLE_BITS-1:0] in_left_i,
  input  logic signed [SAMPLE_BITS-1:0] in_right_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0] out_left_i,
  input  logic signed [SAMPLE_BITS-1:0] out_right_i,
  input  logic [MODE_W-1:0]             mode_now_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam longint FULL_RAMP = 64'd1 << STEP_W;
  localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [MODE_W-1:0]             mode;
  } stereo_out_t;

  stereo_out_t expected_pairs_q[$];

  logic signed [SAMPLE_BITS-1:0] threshold_q;
  logic [RATIO_W-1:0]            inv_ratio_q;
  logic [LEN_W-1:0]              attack_len_q;
  logic [LEN_W-1:0]              knee_len_q;
  logic [LEN_W-1:0]              release_len_q;
  logic [STEP_W-1:0]             knee_step_q;
  logic [STEP_W-1:0]             release_step_q;
  mode_e                         env_mode_q;
  logic [COUNT_BITS-1:0]         phase_q;
  int                            errors;
  int                            pairs_out;

  function automatic longint clamp_q24(input longint prod);
    return (prod > FULL_RAMP) ? FULL_RAMP : prod;
  endfunction

  function automatic stereo_out_t compress_pair(input longint lft, input longint rgt,
                                                output mode_e nxt,
                                                output logic [COUNT_BITS-1:0] cnt_nxt);
    stereo_out_t res;
    longint      thr;
    longint      cnt;
    longint      ramp;
    longint      red;
    logic        apply;
    thr   = threshold_q;
    cnt   = phase_q;
    nxt   = env_mode_q;
    apply = 1'b0;
    ramp  = 0;
    case (env_mode_q)
      ModeAttack: begin
        if (cnt > attack_len_q) nxt = ModeKnee;
      end
      ModeKnee: begin
        if (cnt > knee_len_q) nxt = ModeActive;
        if (lft > thr) begin
          apply = 1'b1;
          ramp  = clamp_q24(cnt * longint'(knee_step_q));
        end
      end
      ModeActive: begin
        if (lft < thr) begin
          nxt = ModeRelease;
        end else begin
          apply = 1'b1;
          ramp  = FULL_RAMP;
        end
      end
      ModeRelease: begin
        if (cnt > release_len_q) nxt = ModeBypass;
        if (lft > thr) begin
          apply = 1'b1;
          ramp  = FULL_RAMP - clamp_q24(cnt * longint'(release_step_q));
        end
      end
      default: begin
        nxt = (lft > thr) ? ModeAttack : ModeBypass;
      end
    endcase
    if (apply) begin
      red       = ((lft - thr) * longint'(inv_ratio_q)) >>> RATIO_W;
      red       = (red * ramp) >>> STEP_W;
      res.left  = lft - red;
      res.right = lft - red;
    end else begin
      res.left  = lft;
      res.right = rgt;
    end
    if (nxt != env_mode_q) cnt = 0;
    if (cnt < COUNT_MAX) cnt++;
    cnt_nxt  = cnt;
    res.mode = nxt;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_out_t           got;
    stereo_out_t           want;
    stereo_out_t           pred;
    mode_e                 nxt;
    logic [COUNT_BITS-1:0] cnt_nxt;
    if (!rst_ni) begin
      threshold_q    <= RstThreshold;
      inv_ratio_q    <= RstInverseRatio;
      attack_len_q   <= RstAttackLength;
      knee_len_q     <= RstKneeLength;
      release_len_q  <= RstReleaseLength;
      knee_step_q    <= RstKneeStep;
      release_step_q <= RstReleaseStep;
      env_mode_q     <= ModeBypass;
      phase_q        <= '0;
      expected_pairs_q.delete();
      errors         = 0;
      pairs_out      = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.left  = out_left_i;
        got.right = out_right_i;
        got.mode  = mode_now_i;
        if (expected_pairs_q.size() == 0) begin
          if (errors < 10)
            $display("transaction %0d unexpected: left %0d right %0d mode %0d",
                     pairs_out, got.left, got.right, got.mode);
          errors++;
        end else begin
          want = expected_pairs_q.pop_front();
          if (got.left !== want.left || got.right !== want.right || got.mode !== want.mode)
          begin
            if (errors < 10)
              $display("transaction %0d: left exp %0d got %0d, right exp %0d got %0d, mode exp %0d got %0d",
                       pairs_out, want.left, got.left, want.right, got.right,
                       want.mode, got.mode);
            errors++;
          end
        end
        pairs_out++;
      end
      if (in_valid_i && !in_stall_i) begin
        pred = compress_pair(in_left_i, in_right_i, nxt, cnt_nxt);
        expected_pairs_q.push_back(pred);
        env_mode_q <= nxt;
        phase_q    <= cnt_nxt;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgThreshold:     threshold_q    <= cfg_wdata_i[SAMPLE_BITS-1:0];
          CfgInverseRatio:  inv_ratio_q    <= cfg_wdata_i[RATIO_W-1:0];
          CfgAttackLength:  attack_len_q   <= cfg_wdata_i[LEN_W-1:0];
          CfgKneeLength:    knee_len_q     <= cfg_wdata_i[LEN_W-1:0];
          CfgReleaseLength: release_len_q  <= cfg_wdata_i[LEN_W-1:0];
          CfgKneeStep:      knee_step_q    <= cfg_wdata_i[STEP_W-1:0];
          CfgReleaseStep:   release_step_q <= cfg_wdata_i[STEP_W-1:0];
          default: ;
        endcase
      end
      fail_count_o <= errors;
      pending_o    <= expected_pairs_q.size();
    end
  end

endmodule

FILE: tb/tb_audio_compressor_envelope_fsm_unit.sv
`timescale 1ns / 100ps
// stimulus and verdict for the compressor envelope block
module tb_audio_compressor_envelope_fsm_unit;
  import acef_pkg::*;

  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned COUNT_BITS    = 21;
  localparam int unsigned WDATA_W       = (SAMPLE_BITS > STEP_W) ? SAMPLE_BITS : STEP_W;
  localparam int unsigned TARGET_PAIRS  = 1150;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CfgUnused = 3'd7;
  localparam int LEN_MAX  = (1 << LEN_W) - 1;
  localparam int STEP_MAX = (1 << STEP_W) - 1;
  localparam int HALF_Q24 = 1 << (STEP_W - 1);
  localparam int EDGE_LEFT[5]  = '{-32768, 32767, 800, 0, -1};
  localparam int EDGE_RIGHT[5] = '{32767, -32768, 0, -1, 0};
  localparam int WALK_LEFT[13] = '{1000, 20000, 20000, 20000, 32767, 0, 32767, -1,
                                   32767, 5000, -5, 100, -32768};

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [CFG_IDX_W-1:0]          cfg_index_i;
  logic [WDATA_W-1:0]            cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] in_left_i;
  logic signed [SAMPLE_BITS-1:0] in_right_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_left_o;
  logic signed [SAMPLE_BITS-1:0] out_right_o;
  logic [MODE_W-1:0]             mode_now_o;

  int fail_count;
  int pending;
  int pairs_sent;
  int thr_now;
  bit no_idle;
  int stall_left = 0;

  audio_compressor_envelope_fsm_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_left_i  (in_left_i),
    .in_right_i (in_right_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_left_o (out_left_o),
    .out_right_o(out_right_o),
    .mode_now_o (mode_now_o)
  );

  compressor_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .WDATA_W    (WDATA_W)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_left_i   (in_left_i),
    .in_right_i  (in_right_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_left_i  (out_left_o),
    .out_right_i (out_right_o),
    .mode_now_i  (mode_now_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(150, 60)
                                                  : $urandom_range(12, 0);
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 10)
                                                  : $urandom_range(3, 0);
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int rand_thr();
    case ($urandom_range(9, 0))
      0:       return -32768;
      1:       return 32767;
      2, 3, 4, 5, 6: return int'($urandom_range(4000, 0)) - 2000;
      default: return int'($urandom_range(65535, 0)) - 32768;
    endcase
  endfunction

  function automatic int rand_ratio();
    case ($urandom_range(5, 0))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(65535, 0);
    endcase
  endfunction

  function automatic int rand_len(input int lo);
    case ($urandom_range(11, 0))
      0:       return LEN_MAX;
      1:       return $urandom_range(LEN_MAX, lo);
      default: return $urandom_range(8, lo);
    endcase
  endfunction

  function automatic int rand_step(input int len);
    int s;
    case ($urandom_range(9, 0))
      0:       return 0;
      1:       return STEP_MAX;
      2:       return $urandom_range(STEP_MAX, 0);
      default: begin
        s = (1 << STEP_W) / len;
        return (s > STEP_MAX) ? STEP_MAX : s;
      end
    endcase
  endfunction

  function automatic int pick_left(input int kind);
    case (kind)
      0, 1, 2, 3, 4: begin
        if (thr_now < 32767)
          return thr_now + 1 + int'($urandom_range(32767 - thr_now - 1, 0));
        return int'($urandom);
      end
      5, 6: begin
        if (thr_now > -32768)
          return thr_now - 1 - int'($urandom_range(thr_now + 32767, 0));
        return int'($urandom);
      end
      7:       return thr_now;
      default: return int'($urandom);
    endcase
  endfunction

  task automatic send_pair(input int l, input int r);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_left_i  <= l[SAMPLE_BITS-1:0];
    in_right_i <= r[SAMPLE_BITS-1:0];
    do @(posedge clk_i); while (in_stall_o);
    pairs_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[WDATA_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_config(input int th, input int ratio, input int atk, input int kl,
                            input int rl, input int ks, input int rs);
    write_reg(CfgThreshold, th & 32'hFFFF);
    write_reg(CfgInverseRatio, ratio);
    write_reg(CfgAttackLength, atk);
    write_reg(CfgKneeLength, kl);
    write_reg(CfgReleaseLength, rl);
    write_reg(CfgKneeStep, ks);
    write_reg(CfgReleaseStep, rs);
    write_reg(CfgUnused, int'($urandom));
    cfg_we_i <= 1'b0;
    thr_now  = th;
  endtask

  initial begin
    int phase;
    int n;
    int kind;
    int seg_left;
    int kl;
    int rl;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_left_i   = '0;
    in_right_i  = '0;
    no_idle     = 1'b0;
    pairs_sent  = 0;
    thr_now     = RstThreshold;
    seg_left    = 0;
    kind        = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes under the reset settings
    for (int k = 0; k < 5; k++) send_pair(EDGE_LEFT[k], EDGE_RIGHT[k]);
    wait_drained();

    // short windows: walk through every mode
    set_config(0, 65535, 0, 2, 2, HALF_Q24, HALF_Q24);
    for (int k = 0; k < 13; k++) send_pair(WALK_LEFT[k], int'($urandom));

    phase = 0;
    while (pairs_sent < TARGET_PAIRS) begin
      wait_drained();
      if (phase == 0) begin
        set_config(-32768, 0, 0, 1, 1, 0, 0);
      end else if (phase == 1) begin
        set_config(32767, 65535, LEN_MAX, LEN_MAX, LEN_MAX, STEP_MAX, STEP_MAX);
      end else begin
        kl = rand_len(1);
        rl = rand_len(1);
        set_config(rand_thr(), rand_ratio(), rand_len(0), kl, rl, rand_step(kl),
                   rand_step(rl));
      end
      no_idle = ($urandom_range(3, 0) == 0);
      n = 24 + $urandom_range(16, 0);
      for (int k = 0; k < n; k++) begin
        if (seg_left == 0) begin
          kind     = $urandom_range(9, 0);
          seg_left = $urandom_range(24, 1);
        end
        seg_left--;
        send_pair(pick_left(kind), int'($urandom));
      end
      phase++;
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
